// File: src/srg_pkg.sv
// ----------------------------------------------------------------------------
// srg_pkg
// Shared types, constants and helpers for the subtractive random generator.
// ----------------------------------------------------------------------------
package srg_pkg;

	localparam int SEED_W      = 32;
	localparam int WORD_W      = 30;
	localparam int TABLE_DEPTH = 55;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [ADDR_W-1:0] addr_t;

	localparam word_t             MODULUS    = WORD_W'(1000000000);
	localparam logic [SEED_W-1:0] SEED_BASE  = SEED_W'(161803398);
	localparam addr_t             LAST_ADDR  = ADDR_W'(TABLE_DEPTH - 1);
	localparam addr_t             PTR_WRAP   = ADDR_W'(TABLE_DEPTH);
	localparam addr_t             SECOND_RST = ADDR_W'(31);
	localparam addr_t             MIX_LAG    = ADDR_W'(31);
	localparam addr_t             SCAT_STEP  = ADDR_W'(21);
	localparam addr_t             SCAT_LAST  = ADDR_W'(TABLE_DEPTH - 1);
	localparam logic [1:0]        LAST_PASS  = 2'd3;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_LOAD_SEED,
		DP_REDUCE,
		DP_INIT,
		DP_SCATTER,
		DP_MIX_RD,
		DP_MIX_WR,
		DP_ADVANCE,
		DP_DRAW_WR
	} dp_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_SCATTER,
		ST_MIX_RD,
		ST_MIX_WR,
		ST_DRAW_RD,
		ST_DRAW_WR
	} srg_state_t;

	typedef struct packed {
		dp_op_t op;
		logic   reseed;
	} dp_cmd_t;

	typedef struct packed {
		logic seed_reduced;
		logic scatter_last;
		logic mix_last;
	} dp_status_t;

	// (a - b) mod MODULUS, both operands already reduced
	function automatic word_t sub_mod(word_t a, word_t b);
		logic [WORD_W:0] d;
		d = {1'b0, a} - {1'b0, b};
		if (d[WORD_W]) begin
			d = d + {1'b0, MODULUS};
		end
		return d[WORD_W-1:0];
	endfunction

	function automatic addr_t ptr_advance(addr_t p);
		return (p >= PTR_WRAP) ? addr_t'(1) : p + addr_t'(1);
	endfunction

endpackage

// File: src/srg_if.sv
// ----------------------------------------------------------------------------
// srg_if
// Valid/ready channels: seed requests in, draws out.
// ----------------------------------------------------------------------------
interface srg_seed_if;
	import srg_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [SEED_W-1:0] seed_value;
	modport source (output valid, output seed_value, input ready);
	modport sink (input valid, input seed_value, output ready);
endinterface

interface srg_draw_if;
	import srg_pkg::*;
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] random_value;
	logic              was_reseeded;
	modport source (output valid, output random_value, output was_reseeded, input ready);
	modport sink (input valid, input random_value, input was_reseeded, output ready);
endinterface

// File: src/srg_ram.sv
// ----------------------------------------------------------------------------
// srg_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module srg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// File: src/srg_datapath.sv
// ----------------------------------------------------------------------------
// srg_datapath
// Lag table, seed reduction, table rebuild walk and the subtractive draw.
// ----------------------------------------------------------------------------
module srg_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  srg_pkg::dp_cmd_t                 cmd,
	output srg_pkg::dp_status_t              status,
	input  logic signed [srg_pkg::SEED_W-1:0] seed_value,
	output srg_pkg::word_t                   random_value,
	output logic                             was_reseeded
);
	import srg_pkg::*;

	logic [SEED_W-1:0] seed_q;
	logic [SEED_W-1:0] mag;
	logic [SEED_W-1:0] diff;
	word_t             cur_q, prev_q;
	addr_t             pos_q, cnt_q;
	addr_t             mix_i_q, mix_b_q;
	logic [1:0]        pass_q;
	addr_t             first_q, second_q;
	addr_t             first_nx, second_nx;
	logic [ADDR_W:0]   pos_sum;
	word_t             out_value_q;
	logic              out_reseed_q;

	logic  we;
	addr_t waddr, raddr_a, raddr_b;
	word_t wdata, rdata_a, rdata_b, diff_word;

	assign mag  = seed_value[SEED_W-1] ? (~seed_value + SEED_W'(1)) : seed_value;
	assign diff = (mag >= SEED_BASE) ? (mag - SEED_BASE) : (SEED_BASE - mag);

	assign first_nx  = ptr_advance(first_q);
	assign second_nx = ptr_advance(second_q);
	assign pos_sum   = {1'b0, pos_q} + {1'b0, SCAT_STEP};
	assign diff_word = sub_mod(rdata_a, rdata_b);

	always_comb begin
		we      = 1'b0;
		waddr   = first_q - addr_t'(1);
		wdata   = diff_word;
		raddr_a = first_q - addr_t'(1);
		raddr_b = second_q - addr_t'(1);
		case (cmd.op)
			DP_INIT: begin
				we    = 1'b1;
				waddr = LAST_ADDR;
				wdata = seed_q[WORD_W-1:0];
			end
			DP_SCATTER: begin
				we    = 1'b1;
				waddr = pos_q - addr_t'(1);
				wdata = prev_q;
			end
			DP_MIX_RD: begin
				raddr_a = mix_i_q;
				raddr_b = mix_b_q;
			end
			DP_MIX_WR: begin
				we      = 1'b1;
				waddr   = mix_i_q;
				raddr_a = mix_i_q;
				raddr_b = mix_b_q;
			end
			DP_ADVANCE: begin
				raddr_a = first_nx - addr_t'(1);
				raddr_b = second_nx - addr_t'(1);
			end
			DP_DRAW_WR: begin
				we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	srg_ram #(
		.WIDTH(WORD_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q  <= '0;
			second_q <= SECOND_RST;
		end else begin
			case (cmd.op)
				DP_INIT: begin
					first_q  <= '0;
					second_q <= SECOND_RST;
				end
				DP_ADVANCE: begin
					first_q  <= first_nx;
					second_q <= second_nx;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_LOAD_SEED: begin
				seed_q <= diff;
			end
			DP_REDUCE: begin
				seed_q <= seed_q - {{(SEED_W-WORD_W){1'b0}}, MODULUS};
			end
			DP_INIT: begin
				cur_q   <= seed_q[WORD_W-1:0];
				prev_q  <= word_t'(1);
				pos_q   <= SCAT_STEP;
				cnt_q   <= addr_t'(1);
				mix_i_q <= '0;
				mix_b_q <= MIX_LAG;
				pass_q  <= '0;
			end
			DP_SCATTER: begin
				cur_q  <= prev_q;
				prev_q <= sub_mod(cur_q, prev_q);
				pos_q  <= (pos_sum >= (ADDR_W+1)'(TABLE_DEPTH))
					? ADDR_W'(pos_sum - (ADDR_W+1)'(TABLE_DEPTH)) : pos_sum[ADDR_W-1:0];
				cnt_q  <= cnt_q + addr_t'(1);
			end
			DP_MIX_WR: begin
				mix_i_q <= (mix_i_q == LAST_ADDR) ? '0 : mix_i_q + addr_t'(1);
				mix_b_q <= (mix_b_q == LAST_ADDR) ? '0 : mix_b_q + addr_t'(1);
				if (mix_i_q == LAST_ADDR) begin
					pass_q <= pass_q + 2'd1;
				end
			end
			DP_DRAW_WR: begin
				out_value_q  <= diff_word;
				out_reseed_q <= cmd.reseed;
			end
			default: begin
			end
		endcase
	end

	assign status.seed_reduced = (seed_q < {{(SEED_W-WORD_W){1'b0}}, MODULUS});
	assign status.scatter_last = (cnt_q == SCAT_LAST);
	assign status.mix_last     = (mix_i_q == LAST_ADDR) && (pass_q == LAST_PASS);

	assign random_value = out_value_q;
	assign was_reseeded = out_reseed_q;

endmodule

// File: src/srg_ctrl.sv
// ----------------------------------------------------------------------------
// srg_ctrl
// Sequencer: request handshake, rebuild walk, draw and output register.
// ----------------------------------------------------------------------------
module srg_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                seed_valid,
	input  logic                seed_neg,
	output logic                seed_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output srg_pkg::dp_cmd_t    cmd,
	input  srg_pkg::dp_status_t status
);
	import srg_pkg::*;

	srg_state_t state_q, state_d;
	logic       seeded_q;
	logic       reseed_q;
	logic       out_valid_q;
	logic       out_load;
	logic       seed_fire;
	logic       need_reseed;

	assign need_reseed = seed_neg || !seeded_q;
	assign seed_fire   = seed_valid && seed_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seeded_q    <= 1'b0;
			reseed_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (seed_fire) begin
				reseed_q <= need_reseed;
			end
			if (state_q == ST_MIX_WR && status.mix_last) begin
				seeded_q <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd.op     = DP_NOP;
		cmd.reseed = reseed_q;
		seed_ready = 1'b0;
		out_load   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				seed_ready = 1'b1;
				if (seed_valid) begin
					if (need_reseed) begin
						cmd.op  = DP_LOAD_SEED;
						state_d = ST_REDUCE;
					end else begin
						cmd.op  = DP_ADVANCE;
						state_d = ST_DRAW_WR;
					end
				end
			end
			ST_REDUCE: begin
				if (status.seed_reduced) begin
					cmd.op  = DP_INIT;
					state_d = ST_SCATTER;
				end else begin
					cmd.op = DP_REDUCE;
				end
			end
			ST_SCATTER: begin
				cmd.op = DP_SCATTER;
				if (status.scatter_last) begin
					state_d = ST_MIX_RD;
				end
			end
			ST_MIX_RD: begin
				cmd.op  = DP_MIX_RD;
				state_d = ST_MIX_WR;
			end
			ST_MIX_WR: begin
				cmd.op  = DP_MIX_WR;
				state_d = status.mix_last ? ST_DRAW_RD : ST_MIX_RD;
			end
			ST_DRAW_RD: begin
				cmd.op  = DP_ADVANCE;
				state_d = ST_DRAW_WR;
			end
			ST_DRAW_WR: begin
				if (!out_valid_q || out_ready) begin
					cmd.op   = DP_DRAW_WR;
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

	a_first_reseeds: assert property (@(posedge clk) disable iff (!arst_n)
		seed_fire && !seeded_q |=> reseed_q && state_q == ST_REDUCE)
		else $error("first request after reset did not rebuild the table");

	a_seeded_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		seeded_q |=> seeded_q)
		else $error("seeded flag dropped");

	a_load_from_draw: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DRAW_WR))
		else $error("output loaded outside the draw write step");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !out_valid_q || out_ready)
		else $error("pending draw overwritten");

endmodule

// File: src/subtractive_random_generator_core.sv
// ----------------------------------------------------------------------------
// subtractive_random_generator_core
// Subtractive lagged random generator (ran3 scheme) with unscaled output.
// ----------------------------------------------------------------------------
// Each seed beat yields one draw beat, an integer below 1000000000. An ordinary
// draw reads the table, then subtracts and writes back on the single write port
// of the 55-word table; the next seed beat is taken only after that write, which
// waits while the output register holds an unaccepted draw. A negative seed, or
// the first beat after reset, first rebuilds the table: the seed is loaded,
// reduced and placed in the last word, then 54 scatter writes and mixing (4
// passes of 55 words, read then write each) precede the draw. A finished draw
// waits in an output register while the next seed beat is taken.
// ----------------------------------------------------------------------------
module subtractive_random_generator_core (
	input  logic       clk,
	input  logic       arst_n,
	srg_seed_if.sink   seed,
	srg_draw_if.source draw
);
	import srg_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	srg_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.seed_valid (seed.valid),
		.seed_neg   (seed.seed_value[SEED_W-1]),
		.seed_ready (seed.ready),
		.out_valid  (draw.valid),
		.out_ready  (draw.ready),
		.cmd        (cmd),
		.status     (status)
	);

	srg_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.seed_value   (seed.seed_value),
		.random_value (draw.random_value),
		.was_reseeded (draw.was_reseeded)
	);

endmodule
